[sv/mphe_pkg.sv]
// ----------------------------------------------------------------------------
// mphe_pkg
// Types and constants of the MessagePack header encoder.
// ----------------------------------------------------------------------------
package mphe_pkg;

    localparam int TYPE_W  = 4;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 32;
    localparam int NB_W    = 4;
    localparam int SER_W   = 8 + VALUE_W;

    // request kinds
    localparam logic [TYPE_W-1:0] REQ_NIL   = 4'd0;
    localparam logic [TYPE_W-1:0] REQ_BOOL  = 4'd1;
    localparam logic [TYPE_W-1:0] REQ_INT   = 4'd2;
    localparam logic [TYPE_W-1:0] REQ_FLT64 = 4'd3;
    localparam logic [TYPE_W-1:0] REQ_STR   = 4'd4;
    localparam logic [TYPE_W-1:0] REQ_BIN   = 4'd5;
    localparam logic [TYPE_W-1:0] REQ_ARRAY = 4'd6;
    localparam logic [TYPE_W-1:0] REQ_MAP   = 4'd7;
    localparam logic [TYPE_W-1:0] REQ_RAW   = 4'd8;

    // payload byte counts after the head byte
    localparam logic [NB_W-1:0] NB_0 = 4'd0;
    localparam logic [NB_W-1:0] NB_1 = 4'd1;
    localparam logic [NB_W-1:0] NB_2 = 4'd2;
    localparam logic [NB_W-1:0] NB_4 = 4'd4;
    localparam logic [NB_W-1:0] NB_8 = 4'd8;

    // head bytes
    localparam logic [7:0] HDR_NIL    = 8'hC0;
    localparam logic [7:0] HDR_FALSE  = 8'hC2;
    localparam logic [7:0] HDR_TRUE   = 8'hC3;
    localparam logic [7:0] HDR_BIN8   = 8'hC4;
    localparam logic [7:0] HDR_BIN16  = 8'hC5;
    localparam logic [7:0] HDR_BIN32  = 8'hC6;
    localparam logic [7:0] HDR_FLT64  = 8'hCB;
    localparam logic [7:0] HDR_UINT8  = 8'hCC;
    localparam logic [7:0] HDR_UINT16 = 8'hCD;
    localparam logic [7:0] HDR_UINT32 = 8'hCE;
    localparam logic [7:0] HDR_UINT64 = 8'hCF;
    localparam logic [7:0] HDR_INT8   = 8'hD0;
    localparam logic [7:0] HDR_INT16  = 8'hD1;
    localparam logic [7:0] HDR_INT32  = 8'hD2;
    localparam logic [7:0] HDR_INT64  = 8'hD3;
    localparam logic [7:0] HDR_STR8   = 8'hD9;
    localparam logic [7:0] HDR_STR16  = 8'hDA;
    localparam logic [7:0] HDR_STR32  = 8'hDB;
    localparam logic [7:0] HDR_ARR16  = 8'hDC;
    localparam logic [7:0] HDR_ARR32  = 8'hDD;
    localparam logic [7:0] HDR_MAP16  = 8'hDE;
    localparam logic [7:0] HDR_MAP32  = 8'hDF;
    localparam logic [7:0] HDR_NEGFIX = 8'hE0;
    localparam logic [7:0] HDR_FIXSTR = 8'hA0;
    localparam logic [7:0] HDR_FIXARR = 8'h90;
    localparam logic [7:0] HDR_FIXMAP = 8'h80;

    // range flags taken at the input stage
    typedef struct packed {
        logic v_le7f;    // value <= 0x7F
        logic v_le8;     // value fits 8 bits
        logic v_le16;
        logic v_le32;
        logic v_neg5;    // value >= -32 as signed
        logic v_pos;     // value >= 0 as signed
        logic v_neg8;    // value >= -128 as signed
        logic v_neg16;
        logic v_neg32;
        logic c_le15;
        logic c_le31;
        logic c_le255;
        logic c_le16;
    } range_t;

    typedef struct packed {
        logic [7:0]         head;
        logic [NB_W-1:0]    nbytes;
        logic [VALUE_W-1:0] payload;   // first payload byte in the top bits
    } token_t;

endpackage

[sv/messagepack_header_encoder_unit.sv]
// ----------------------------------------------------------------------------
// messagepack_header_encoder_unit
// Encodes one token request into its MessagePack bytes, most significant
// first, with tlast on the final byte of each request.
// ----------------------------------------------------------------------------
// Registered path: stage 1, stage 2, byte serializer. Throughput: one byte
// per cycle while m_axis_tready is high; a request of n bytes (1 to 9) holds
// the serializer until its last byte, so one-byte tokens pass one per cycle.
// Unknown request kinds are dropped in the decode stage and emit nothing.
// Reset (aresetn low, synchronous) clears all stage valid bits.
module messagepack_header_encoder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // value[63:0], count[95:64]
    input  logic [4:0]   s_axis_tuser,   // req_type[3:0], is_negative[4]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // out_byte[7:0]
    output logic         m_axis_tlast    // last_byte
);

    // ---------------- stage 1: capture and range flags ----------------
    logic                          s1_valid_reg;
    logic [mphe_pkg::TYPE_W-1:0]   s1_type_reg;
    logic [mphe_pkg::VALUE_W-1:0]  s1_value_reg;
    logic                          s1_neg_reg;
    logic [mphe_pkg::COUNT_W-1:0]  s1_count_reg;
    mphe_pkg::range_t              s1_range_reg;
    mphe_pkg::range_t              s1_range_next;

    logic [mphe_pkg::VALUE_W-1:0]  in_value;
    logic [mphe_pkg::COUNT_W-1:0]  in_count;
    logic                          s_fire;
    logic                          s1_take;

    // ---------------- stage 2: decoded token ----------------
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    mphe_pkg::token_t              s2_tok_reg;
    mphe_pkg::token_t              s2_tok_next;
    logic                          s2_ready;

    // ---------------- stage 3: byte serializer ----------------
    logic                          ser_valid_reg;
    logic                          ser_valid_next;
    logic [mphe_pkg::SER_W-1:0]    ser_data_reg;
    logic [mphe_pkg::SER_W-1:0]    ser_data_next;
    logic [mphe_pkg::NB_W-1:0]     ser_cnt_reg;
    logic [mphe_pkg::NB_W-1:0]     ser_cnt_next;
    logic                          ser_load;
    logic                          m_fire;

    logic                          known;
    logic [mphe_pkg::VALUE_W-1:0]  src;
    logic [mphe_pkg::VALUE_W-1:0]  cnt_ext;

    assign in_value = s_axis_tdata[63:0];
    assign in_count = s_axis_tdata[95:64];

    assign m_fire   = m_axis_tvalid && m_axis_tready;
    assign ser_load = s2_valid_reg && (!ser_valid_reg ||
                      (m_axis_tready && ser_cnt_reg == 4'd1));
    assign s2_ready = !s2_valid_reg || ser_load;
    assign s1_take  = s1_valid_reg && s2_ready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign s_fire   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        s1_range_next.v_le7f  = (in_value[63:7] == '0);
        s1_range_next.v_le8   = (in_value[63:8] == '0);
        s1_range_next.v_le16  = (in_value[63:16] == '0);
        s1_range_next.v_le32  = (in_value[63:32] == '0);
        s1_range_next.v_neg5  = (&in_value[63:5]);
        s1_range_next.v_pos   = !in_value[63];
        s1_range_next.v_neg8  = (&in_value[63:7]);
        s1_range_next.v_neg16 = (&in_value[63:15]);
        s1_range_next.v_neg32 = (&in_value[63:31]);
        s1_range_next.c_le15  = (in_count[31:4] == '0);
        s1_range_next.c_le31  = (in_count[31:5] == '0);
        s1_range_next.c_le255 = (in_count[31:8] == '0);
        s1_range_next.c_le16  = (in_count[31:16] == '0);
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_type_reg  <= s_axis_tuser[3:0];
            s1_neg_reg   <= s_axis_tuser[4];
            s1_value_reg <= in_value;
            s1_count_reg <= in_count;
            s1_range_reg <= s1_range_next;
        end
    end

    // decode: head byte, payload length and aligned payload
    assign cnt_ext = {{(mphe_pkg::VALUE_W-mphe_pkg::COUNT_W){1'b0}}, s1_count_reg};

    always_comb begin
        mphe_pkg::range_t r;
        r     = s1_range_reg;
        known = 1'b1;
        src   = s1_value_reg;
        s2_tok_next.head   = mphe_pkg::HDR_NIL;
        s2_tok_next.nbytes = mphe_pkg::NB_0;
        unique case (s1_type_reg)
            mphe_pkg::REQ_NIL: begin
                s2_tok_next.head = mphe_pkg::HDR_NIL;
            end
            mphe_pkg::REQ_BOOL: begin
                s2_tok_next.head = s1_value_reg[0] ? mphe_pkg::HDR_TRUE
                                                   : mphe_pkg::HDR_FALSE;
            end
            mphe_pkg::REQ_INT: begin
                if (!s1_neg_reg) begin
                    priority if (r.v_le7f) begin
                        s2_tok_next.head = s1_value_reg[7:0];
                    end else if (r.v_le8) begin
                        s2_tok_next.head   = mphe_pkg::HDR_UINT8;
                        s2_tok_next.nbytes = mphe_pkg::NB_1;
                    end else if (r.v_le16) begin
                        s2_tok_next.head   = mphe_pkg::HDR_UINT16;
                        s2_tok_next.nbytes = mphe_pkg::NB_2;
                    end else if (r.v_le32) begin
                        s2_tok_next.head   = mphe_pkg::HDR_UINT32;
                        s2_tok_next.nbytes = mphe_pkg::NB_4;
                    end else begin
                        s2_tok_next.head   = mphe_pkg::HDR_UINT64;
                        s2_tok_next.nbytes = mphe_pkg::NB_8;
                    end
                end else begin
                    priority if (r.v_neg5 || r.v_pos) begin
                        s2_tok_next.head = mphe_pkg::HDR_NEGFIX | s1_value_reg[7:0];
                    end else if (r.v_neg8) begin
                        s2_tok_next.head   = mphe_pkg::HDR_INT8;
                        s2_tok_next.nbytes = mphe_pkg::NB_1;
                    end else if (r.v_neg16) begin
                        s2_tok_next.head   = mphe_pkg::HDR_INT16;
                        s2_tok_next.nbytes = mphe_pkg::NB_2;
                    end else if (r.v_neg32) begin
                        s2_tok_next.head   = mphe_pkg::HDR_INT32;
                        s2_tok_next.nbytes = mphe_pkg::NB_4;
                    end else begin
                        s2_tok_next.head   = mphe_pkg::HDR_INT64;
                        s2_tok_next.nbytes = mphe_pkg::NB_8;
                    end
                end
            end
            mphe_pkg::REQ_FLT64: begin
                s2_tok_next.head   = mphe_pkg::HDR_FLT64;
                s2_tok_next.nbytes = mphe_pkg::NB_8;
            end
            mphe_pkg::REQ_STR: begin
                src = cnt_ext;
                priority if (r.c_le31) begin
                    s2_tok_next.head = mphe_pkg::HDR_FIXSTR | {3'b000, s1_count_reg[4:0]};
                end else if (r.c_le255) begin
                    s2_tok_next.head   = mphe_pkg::HDR_STR8;
                    s2_tok_next.nbytes = mphe_pkg::NB_1;
                end else if (r.c_le16) begin
                    s2_tok_next.head   = mphe_pkg::HDR_STR16;
                    s2_tok_next.nbytes = mphe_pkg::NB_2;
                end else begin
                    s2_tok_next.head   = mphe_pkg::HDR_STR32;
                    s2_tok_next.nbytes = mphe_pkg::NB_4;
                end
            end
            mphe_pkg::REQ_BIN: begin
                src = cnt_ext;
                priority if (r.c_le15) begin
                    s2_tok_next.head   = mphe_pkg::HDR_BIN8;
                    s2_tok_next.nbytes = mphe_pkg::NB_1;
                end else if (r.c_le16) begin
                    s2_tok_next.head   = mphe_pkg::HDR_BIN16;
                    s2_tok_next.nbytes = mphe_pkg::NB_2;
                end else begin
                    s2_tok_next.head   = mphe_pkg::HDR_BIN32;
                    s2_tok_next.nbytes = mphe_pkg::NB_4;
                end
            end
            mphe_pkg::REQ_ARRAY: begin
                src = cnt_ext;
                priority if (r.c_le15) begin
                    s2_tok_next.head = mphe_pkg::HDR_FIXARR | {4'b0000, s1_count_reg[3:0]};
                end else if (r.c_le16) begin
                    s2_tok_next.head   = mphe_pkg::HDR_ARR16;
                    s2_tok_next.nbytes = mphe_pkg::NB_2;
                end else begin
                    s2_tok_next.head   = mphe_pkg::HDR_ARR32;
                    s2_tok_next.nbytes = mphe_pkg::NB_4;
                end
            end
            mphe_pkg::REQ_MAP: begin
                src = cnt_ext;
                priority if (r.c_le15) begin
                    s2_tok_next.head = mphe_pkg::HDR_FIXMAP | {4'b0000, s1_count_reg[3:0]};
                end else if (r.c_le16) begin
                    s2_tok_next.head   = mphe_pkg::HDR_MAP16;
                    s2_tok_next.nbytes = mphe_pkg::NB_2;
                end else begin
                    s2_tok_next.head   = mphe_pkg::HDR_MAP32;
                    s2_tok_next.nbytes = mphe_pkg::NB_4;
                end
            end
            mphe_pkg::REQ_RAW: begin
                s2_tok_next.head = s1_value_reg[7:0];
            end
            default: begin
                known = 1'b0;
            end
        endcase

        unique case (s2_tok_next.nbytes)
            mphe_pkg::NB_1: s2_tok_next.payload = {src[7:0], 56'd0};
            mphe_pkg::NB_2: s2_tok_next.payload = {src[15:0], 48'd0};
            mphe_pkg::NB_4: s2_tok_next.payload = {src[31:0], 32'd0};
            default:        s2_tok_next.payload = src;
        endcase
    end

    assign s2_valid_next = s1_take ? known : (s2_valid_reg && !ser_load);

    always_ff @(posedge aclk) begin
        if (s1_take) begin
            s2_tok_reg <= s2_tok_next;
        end
    end

    // serializer: head byte then payload bytes from the top
    always_comb begin
        ser_valid_next = ser_valid_reg;
        ser_data_next  = ser_data_reg;
        ser_cnt_next   = ser_cnt_reg;
        if (ser_load) begin
            ser_valid_next = 1'b1;
            ser_data_next  = {s2_tok_reg.head, s2_tok_reg.payload};
            ser_cnt_next   = s2_tok_reg.nbytes + 4'd1;
        end else if (m_fire) begin
            ser_valid_next = (ser_cnt_reg != 4'd1);
            ser_data_next  = {ser_data_reg[mphe_pkg::SER_W-9:0], 8'd0};
            ser_cnt_next   = ser_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        ser_data_reg <= ser_data_next;
        ser_cnt_reg  <= ser_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s_fire || (s1_valid_reg && !s2_ready);
            s2_valid_reg  <= s2_valid_next;
            ser_valid_reg <= ser_valid_next;
        end
    end

    assign m_axis_tvalid = ser_valid_reg;
    assign m_axis_tdata  = ser_data_reg[mphe_pkg::SER_W-1:mphe_pkg::SER_W-8];
    assign m_axis_tlast  = (ser_cnt_reg == 4'd1);

    // ---------------- assertions ----------------
    a_ser_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> (ser_cnt_reg != 4'd0 && ser_cnt_reg <= 4'd9))
        else $error("serializer byte count out of range");

    a_token_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a multi-byte token");

    a_drain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_axis_tlast && !s2_valid_reg) |=> !m_axis_tvalid)
        else $error("serializer not empty after final byte");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |=>
            (s1_valid_reg && $stable(s1_type_reg) && $stable(s1_value_reg)))
        else $error("stage 1 lost a stalled request");

endmodule

[verif/messagepack_header_encoder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// messagepack_header_encoder_unit_tb
// Drives token requests into the encoder and checks every output byte and its
// tlast against table bytes or an in-bench encoder model. A directed table
// covers the form boundaries, the signed corner cases and the dropped request
// kinds; random requests follow, with header plus payload runs, under three
// idle profiles and one long receiver hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module messagepack_header_encoder_unit_tb;

    localparam int NDIR        = 25;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_TAIL  = 20;

    localparam logic [mphe_pkg::TYPE_W-1:0] REQ_UNKNOWN_LO = 4'd9;
    localparam logic [mphe_pkg::TYPE_W-1:0] REQ_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [mphe_pkg::TYPE_W-1:0]  kind;
        logic [mphe_pkg::VALUE_W-1:0] value;
        logic                         neg;
        logic [mphe_pkg::COUNT_W-1:0] count;
        logic                         typed;  // bytes below are given, not predicted
        logic [3:0]                   nb;
        logic [71:0]                  bytes;  // right-aligned, first byte highest
    } req_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata  = '0;
    logic [4:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;

    bit        in_fire  = 1'b0;
    bit        out_fire = 1'b0;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        hold_events = 0;
    int        mismatches  = 0;
    int        stall_cycles = 0;
    enc_byte_t encoded_bytes_q[$];

    req_row_t dir_rows [NDIR] = '{
        '{mphe_pkg::REQ_NIL, 64'h0, 1'b0, 32'h0, 1'b1, 4'd1, 72'hC0},
        '{mphe_pkg::REQ_BOOL, 64'h1, 1'b0, 32'h0, 1'b1, 4'd1, 72'hC3},
        '{mphe_pkg::REQ_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd1, 72'hC2},
        '{mphe_pkg::REQ_INT, 64'h0, 1'b0, 32'h0, 1'b1, 4'd1, 72'h00},
        '{mphe_pkg::REQ_INT, 64'h7F, 1'b0, 32'h0, 1'b1, 4'd1, 72'h7F},
        '{mphe_pkg::REQ_INT, 64'h80, 1'b0, 32'h0, 1'b1, 4'd2, 72'hCC80},
        '{mphe_pkg::REQ_INT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0, 1'b1, 4'd9,
          72'hCF_FFFF_FFFF_FFFF_FFFF},
        '{mphe_pkg::REQ_INT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0, 1'b1, 4'd1, 72'hFF},
        '{mphe_pkg::REQ_INT, 64'hFFFF_FFFF_FFFF_FFE0, 1'b1, 32'h0, 1'b1, 4'd1, 72'hE0},
        '{mphe_pkg::REQ_INT, 64'hFFFF_FFFF_FFFF_FFDF, 1'b1, 32'h0, 1'b1, 4'd2, 72'hD0DF},
        '{mphe_pkg::REQ_INT, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1, 32'h0, 1'b0, 4'd0, 72'h0},
        '{mphe_pkg::REQ_INT, 64'h8000_0000_0000_0000, 1'b1, 32'h0, 1'b1, 4'd9,
          72'hD3_8000_0000_0000_0000},
        // negative flag on a non-negative value folds into the negative fixint
        '{mphe_pkg::REQ_INT, 64'h5, 1'b1, 32'h0, 1'b1, 4'd1, 72'hE5},
        '{mphe_pkg::REQ_INT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 32'h0, 1'b1, 4'd1, 72'hFF},
        '{mphe_pkg::REQ_FLT64, 64'h4009_21FB_5444_2D18, 1'b0, 32'h0, 1'b0, 4'd0, 72'h0},
        '{mphe_pkg::REQ_STR, 64'h0, 1'b0, 32'd31, 1'b1, 4'd1, 72'hBF},
        '{mphe_pkg::REQ_STR, 64'h0, 1'b0, 32'd32, 1'b1, 4'd2, 72'hD920},
        '{mphe_pkg::REQ_STR, 64'h0, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'd5,
          72'hDB_FFFF_FFFF},
        '{mphe_pkg::REQ_BIN, 64'h0, 1'b0, 32'd15, 1'b1, 4'd2, 72'hC40F},
        '{mphe_pkg::REQ_BIN, 64'h0, 1'b0, 32'd16, 1'b1, 4'd3, 72'hC50010},
        '{mphe_pkg::REQ_ARRAY, 64'h0, 1'b0, 32'd65535, 1'b0, 4'd0, 72'h0},
        '{mphe_pkg::REQ_MAP, 64'h0, 1'b0, 32'd65536, 1'b1, 4'd5,
          72'hDF_0001_0000},
        '{mphe_pkg::REQ_RAW, 64'hFFFF_FFFF_FFFF_FFAB, 1'b0, 32'h0, 1'b1, 4'd1, 72'hAB},
        // unknown kinds are dropped
        '{REQ_UNKNOWN_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd0, 72'h0},
        '{REQ_UNKNOWN_HI, 64'h0, 1'b0, 32'h0, 1'b1, 4'd0, 72'h0}
    };

    messagepack_header_encoder_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 aclk = ~aclk;

    // Returns the number of encoded bytes; seq holds them right-aligned.
    function automatic int encode_token(input logic [mphe_pkg::TYPE_W-1:0] kind,
                                        input logic [mphe_pkg::VALUE_W-1:0] v,
                                        input logic neg,
                                        input logic [mphe_pkg::COUNT_W-1:0] cnt,
                                        output logic [71:0] seq);
        logic [7:0]                   head;
        int                           plen;
        logic [mphe_pkg::VALUE_W-1:0] pay;
        logic [mphe_pkg::VALUE_W-1:0] mag;
        head = mphe_pkg::HDR_NIL;
        plen = 0;
        pay  = v;
        seq  = '0;
        case (kind)
            mphe_pkg::REQ_NIL:   head = mphe_pkg::HDR_NIL;
            mphe_pkg::REQ_BOOL:  head = v[0] ? mphe_pkg::HDR_TRUE : mphe_pkg::HDR_FALSE;
            mphe_pkg::REQ_INT: begin
                mag = neg ? (((~v + 64'd1) << 1) - 64'd1) : v;
                if (!neg && v <= 64'h7F) begin
                    head = v[7:0];
                end else if (neg && (v >= 64'hFFFF_FFFF_FFFF_FFE0 || !v[63])) begin
                    head = mphe_pkg::HDR_NEGFIX | v[7:0];
                end else if (mag <= 64'hFF) begin
                    head = neg ? mphe_pkg::HDR_INT8 : mphe_pkg::HDR_UINT8;
                    plen = 1;
                end else if (mag <= 64'hFFFF) begin
                    head = neg ? mphe_pkg::HDR_INT16 : mphe_pkg::HDR_UINT16;
                    plen = 2;
                end else if (mag <= 64'hFFFF_FFFF) begin
                    head = neg ? mphe_pkg::HDR_INT32 : mphe_pkg::HDR_UINT32;
                    plen = 4;
                end else begin
                    head = neg ? mphe_pkg::HDR_INT64 : mphe_pkg::HDR_UINT64;
                    plen = 8;
                end
            end
            mphe_pkg::REQ_FLT64: begin
                head = mphe_pkg::HDR_FLT64;
                plen = 8;
            end
            mphe_pkg::REQ_STR: begin
                pay = 64'(cnt);
                if (cnt <= 31) begin
                    head = mphe_pkg::HDR_FIXSTR | cnt[7:0];
                end else if (cnt <= 255) begin
                    head = mphe_pkg::HDR_STR8;
                    plen = 1;
                end else if (cnt <= 65535) begin
                    head = mphe_pkg::HDR_STR16;
                    plen = 2;
                end else begin
                    head = mphe_pkg::HDR_STR32;
                    plen = 4;
                end
            end
            mphe_pkg::REQ_BIN: begin
                pay = 64'(cnt);
                if (cnt <= 15) begin
                    head = mphe_pkg::HDR_BIN8;
                    plen = 1;
                end else if (cnt <= 65535) begin
                    head = mphe_pkg::HDR_BIN16;
                    plen = 2;
                end else begin
                    head = mphe_pkg::HDR_BIN32;
                    plen = 4;
                end
            end
            mphe_pkg::REQ_ARRAY: begin
                pay = 64'(cnt);
                if (cnt <= 15) begin
                    head = mphe_pkg::HDR_FIXARR | cnt[7:0];
                end else if (cnt <= 65535) begin
                    head = mphe_pkg::HDR_ARR16;
                    plen = 2;
                end else begin
                    head = mphe_pkg::HDR_ARR32;
                    plen = 4;
                end
            end
            mphe_pkg::REQ_MAP: begin
                pay = 64'(cnt);
                if (cnt <= 15) begin
                    head = mphe_pkg::HDR_FIXMAP | cnt[7:0];
                end else if (cnt <= 65535) begin
                    head = mphe_pkg::HDR_MAP16;
                    plen = 2;
                end else begin
                    head = mphe_pkg::HDR_MAP32;
                    plen = 4;
                end
            end
            mphe_pkg::REQ_RAW:   head = v[7:0];
            default:   return 0;
        endcase
        seq = (72'(head) << (8 * plen)) | (72'(pay) & ((72'd1 << (8 * plen)) - 72'd1));
        return plen + 1;
    endfunction

    function automatic void queue_encoding(input logic [71:0] seq, input int nb);
        enc_byte_t e;
        for (int k = 0; k < nb; k++) begin
            e.data = seq[8 * (nb - 1 - k) +: 8];
            e.last = (k == nb - 1);
            encoded_bytes_q.push_back(e);
        end
    endfunction

    function automatic logic [mphe_pkg::VALUE_W-1:0] rand_value();
        logic [mphe_pkg::VALUE_W-1:0] r;
        int                           w;
        r = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return r;
            1: begin
                w = $urandom_range(1, 64);
                return r >> (64 - w);
            end
            2: begin
                w = $urandom_range(1, 64);
                return -(r >> (64 - w));
            end
            default: begin
                w = $urandom_range(0, 63);
                r = (64'd1 << w) + 64'($urandom_range(2)) - 64'd1;
                return $urandom_range(1) ? -r : r;
            end
        endcase
    endfunction

    function automatic logic [mphe_pkg::COUNT_W-1:0] rand_count();
        int w;
        case ($urandom_range(2))
            0: return $urandom;
            1: begin
                w = $urandom_range(0, 32);
                return (w == 0) ? 32'd0 : ($urandom >> (32 - w));
            end
            default: begin
                case ($urandom_range(3))
                    0: return 32'd15 + $urandom_range(1);
                    1: return 32'd31 + $urandom_range(1);
                    2: return 32'd255 + $urandom_range(1);
                    default: return 32'd65535 + $urandom_range(1);
                endcase
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_req(input req_row_t r);
        logic [71:0] seq;
        int          nb;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.count, r.value};
        s_axis_tuser  <= {r.neg, r.kind};
        do @(posedge aclk); while (!in_fire);
        if (r.typed) begin
            queue_encoding(r.bytes, r.nb);
        end else begin
            nb = encode_token(r.kind, r.value, r.neg, r.count, seq);
            queue_encoding(seq, nb);
        end
    endtask

    task automatic run_random(input int n_items);
        req_row_t r;
        int       sent;
        int       pick;
        sent = 0;
        while (sent < n_items) begin
            r       = '0;
            r.value = rand_value();
            r.count = rand_count();
            r.neg   = 1'($urandom_range(1));
            pick    = $urandom_range(99);
            if (pick < 6) begin
                r.kind = 4'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
            end else if (pick < 35) begin
                r.kind = mphe_pkg::REQ_INT;
                if ($urandom_range(9) != 0) r.neg = r.value[63];
            end else begin
                r.kind = 4'($urandom_range(mphe_pkg::REQ_NIL, mphe_pkg::REQ_RAW));
            end
            if ((r.kind == mphe_pkg::REQ_STR || r.kind == mphe_pkg::REQ_BIN) &&
                $urandom_range(1))
                r.count = $urandom_range(0, 6);
            send_req(r);
            if (r.kind <= mphe_pkg::REQ_RAW) sent++;
            // short str/bin: follow the header with its payload bytes
            if ((r.kind == mphe_pkg::REQ_STR || r.kind == mphe_pkg::REQ_BIN) &&
                r.count <= 6) begin
                for (int k = 0; k < r.count; k++) begin
                    r.kind  = mphe_pkg::REQ_RAW;
                    r.value = rand_value();
                    send_req(r);
                    sent++;
                end
            end
        end
    endtask

    // Handshakes and output checks are sampled mid-cycle, away from the edge.
    always @(negedge aclk) begin
        enc_byte_t want;
        in_fire  = aresetn && s_axis_tvalid && s_axis_tready;
        out_fire = aresetn && m_axis_tvalid && m_axis_tready;
        if (out_fire) begin
            if (encoded_bytes_q.size() == 0) begin
                $error("out_byte: unexpected transfer %02h, last_byte %0b",
                       m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = encoded_bytes_q.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_byte: expected %0b, got %0b", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int seen;
        int hold_left;
        seen      = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_events != seen) begin
                seen      = hold_events;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || in_fire || out_fire) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        tx_idle_pct = 37;
        rx_idle_pct = 51;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NDIR; i++) send_req(dir_rows[i]);
        run_random(40);

        tx_idle_pct = 51;
        rx_idle_pct = 37;
        run_random(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_events++;
        run_random(40);

        s_axis_tvalid <= 1'b0;
        while (encoded_bytes_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[messagepack_header_encoder_unit.f]
sv/mphe_pkg.sv
sv/messagepack_header_encoder_unit.sv
verif/messagepack_header_encoder_unit_tb.sv
